>>> src/assert_macros.svh
// assertion helpers shared by the console modules
// both sample on the rising edge of clock and are off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define TCW_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define TCW_CHECK_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> src/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

   // action codes
   localparam logic [2:0] ACT_PUT     = 3'd0;
   localparam logic [2:0] ACT_NEWLINE = 3'd1;
   localparam logic [2:0] ACT_UDEC    = 3'd2;
   localparam logic [2:0] ACT_SDEC    = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;
   localparam logic [2:0] ACT_READ    = 3'd5;

   localparam logic [7:0] SPACE_CODE  = 8'h20;
   localparam logic [7:0] MINUS_CODE  = 8'h2D;
   localparam logic [7:0] RESET_COLOR = 8'h0F;
   localparam logic [7:0] BLANK_COLOR_RESET = 8'd15;
   localparam int DIGITS   = 10;
   localparam int NUM_BITS = 32;

   typedef enum logic [11:0] {
      ST_INIT      = 12'b0000_0000_0001,
      ST_IDLE      = 12'b0000_0000_0010,
      ST_PUT       = 12'b0000_0000_0100,
      ST_NEWLINE   = 12'b0000_0000_1000,
      ST_POSTMOVE  = 12'b0000_0001_0000,
      ST_SCROLL    = 12'b0000_0010_0000,
      ST_CONV      = 12'b0000_0100_0000,
      ST_DIGIT     = 12'b0000_1000_0000,
      ST_CLEAR     = 12'b0001_0000_0000,
      ST_READ      = 12'b0010_0000_0000,
      ST_READ_WAIT = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic fill_init;
      logic fill_clear;
      logic scroll;
      logic put_char;
      logic put_minus;
      logic put_digit;
      logic skip_digit;
      logic newline;
      logic conv_step;
      logic read_issue;
      logic read_capture;
      logic home;
      logic rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic scroll_end;
      logic scroll_need;
      logic conv_done;
      logic sign_pending;
      logic dig_live;
      logic digit_skip;
      logic rsp_free;
   } status_type;

endpackage

>>> src/tcw_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_action,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_init = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_PUT:     state_in = ST_PUT;
                  ACT_NEWLINE: state_in = ST_NEWLINE;
                  ACT_UDEC:    state_in = ST_CONV;
                  ACT_SDEC:    state_in = ST_CONV;
                  ACT_CLEAR:   state_in = ST_CLEAR;
                  ACT_READ:    state_in = ST_READ;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_PUT: begin
            cmd.put_char = 1'b1;
            state_in     = ST_POSTMOVE;
         end
         ST_NEWLINE: begin
            cmd.newline = 1'b1;
            state_in    = ST_POSTMOVE;
         end
         ST_POSTMOVE: begin
            if (status.scroll_need) state_in = ST_SCROLL;
            else if (status.sign_pending || status.dig_live) state_in = ST_DIGIT;
            else state_in = ST_DONE;
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
            if (status.scroll_end) state_in = ST_POSTMOVE;
         end
         ST_CONV: begin
            if (status.conv_done) state_in = ST_DIGIT;
            else cmd.conv_step = 1'b1;
         end
         ST_DIGIT: begin
            if (status.sign_pending) begin
               cmd.put_minus = 1'b1;
               state_in      = ST_POSTMOVE;
            end else if (status.digit_skip) begin
               cmd.skip_digit = 1'b1;
            end else begin
               cmd.put_digit = 1'b1;
               state_in      = ST_POSTMOVE;
            end
         end
         ST_CLEAR: begin
            cmd.fill_clear = 1'b1;
            if (status.sweep_last) begin
               cmd.home = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   `TCW_CHECK_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != ST_IDLE, "accepted transfer left controller idle")
   `TCW_CHECK(a_one_write_source, $countones({cmd.fill_init, cmd.fill_clear, cmd.put_char, cmd.put_minus, cmd.put_digit}) <= 1, "two cell write sources at once")

endmodule

>>> src/tcw_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_character,
   input  logic [7:0]  req_color,
   input  logic [31:0] req_number,
   input  logic [10:0] req_cell_address,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_read_character,
   output logic [7:0]  rsp_read_color
);

   localparam int CELLS    = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int COPY_LEN = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
   localparam int AW = $clog2(CELLS);
   localparam int NW = $clog2(CELLS + 1);
   localparam int RW = $clog2(SCREEN_ROWS + 1);
   localparam int CW = $clog2(SCREEN_COLUMNS);
   localparam int BW = $clog2(NUM_BITS + 1);
   localparam int DW = $clog2(DIGITS);

   // screen store
   logic [15:0] mem [CELLS];
   logic        we;
   logic [AW-1:0] wa;
   logic [15:0] wd;
   logic        re;
   logic [AW-1:0] ra;
   logic [15:0] rd_q_ff;

   logic [7:0]  blank_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [NW-1:0] cnt_ff;
   logic        pv_ff, cp_ff;
   logic [AW-1:0] pa_ff;

   logic [7:0]  char_ff, color_ff;
   logic [10:0] addr_ff;
   logic [31:0] bin_ff;
   logic [4*DIGITS-1:0] bcd_ff, adj;
   logic [BW-1:0] bits_ff;
   logic [DW-1:0] di_ff;
   logic        sign_ff, started_ff, live_ff;
   logic [3:0]  digit;
   logic [7:0]  rdc_ff, rda_ff;
   logic        rsp_valid_ff;
   logic [4:0]  o_row_ff;
   logic [6:0]  o_col_ff;
   logic [10:0] o_pos_ff;
   logic [7:0]  o_ch_ff, o_co_ff;
   logic        put_any;
   logic [7:0]  put_ch;
   logic [AW-1:0] cur_pos;
   logic        addr_ok;

   assign cur_pos = AW'(row_ff * SCREEN_COLUMNS + col_ff);
   assign digit   = bcd_ff[di_ff*4 +: 4];
   assign addr_ok = (32'(addr_ff) < CELLS);
   assign put_any = cmd.put_char | cmd.put_minus | cmd.put_digit;

   // character to put
   always_comb begin
      if (cmd.put_minus) put_ch = MINUS_CODE;
      else if (cmd.put_digit) put_ch = {4'h3, digit};
      else put_ch = char_ff;
   end

   // write port select
   always_comb begin
      we = 1'b0;
      wa = cur_pos;
      wd = {color_ff, put_ch};
      if (pv_ff) begin
         we = 1'b1;
         wa = pa_ff;
         wd = cp_ff ? rd_q_ff : {blank_ff, SPACE_CODE};
      end else if (cmd.fill_init) begin
         we = 1'b1;
         wa = cnt_ff[AW-1:0];
         wd = {RESET_COLOR, SPACE_CODE};
      end else if (cmd.fill_clear) begin
         we = 1'b1;
         wa = cnt_ff[AW-1:0];
         wd = {blank_ff, SPACE_CODE};
      end else if (put_any) begin
         we = 1'b1;
      end
   end

   // read port select
   always_comb begin
      if (cmd.scroll) begin
         re = (cnt_ff < NW'(COPY_LEN));
         ra = AW'(cnt_ff + NW'(SCREEN_COLUMNS));
      end else begin
         re = cmd.read_issue & addr_ok;
         ra = AW'(addr_ff);
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   // memory read
   always_ff @(posedge clock) begin
      if (re) begin
         rd_q_ff <= mem[ra];
      end
   end

   // sweep counter and scroll copy pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pv_ff  <= 1'b0;
      end else begin
         cnt_ff <= (cmd.fill_init | cmd.fill_clear | cmd.scroll) ? cnt_ff + 1'b1 : '0;
         pv_ff  <= cmd.scroll & (cnt_ff != NW'(CELLS));
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= cnt_ff[AW-1:0];
      cp_ff <= (cnt_ff < NW'(COPY_LEN));
   end

   // blank color register
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff <= BLANK_COLOR_RESET;
      end else if (csr_write_enable) begin
         blank_ff <= csr_write_data;
      end
   end

   // cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (put_any) begin
         if (32'(col_ff) == SCREEN_COLUMNS - 1) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else if (cmd.newline) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else if (cmd.scroll && status.scroll_end) begin
         row_in = RW'(SCREEN_ROWS - 1);
      end else if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // binary to decimal adjust
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         adj[k*4 +: 4] = (bcd_ff[k*4 +: 4] >= 4'd5) ? bcd_ff[k*4 +: 4] + 4'd3
                                                   : bcd_ff[k*4 +: 4];
      end
   end

   // item capture and decimal conversion
   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff    <= 1'b0;
         live_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else if (cmd.capture) begin
         sign_ff    <= (req_action == ACT_SDEC) && req_number[31];
         live_ff    <= req_action inside {ACT_UDEC, ACT_SDEC};
         started_ff <= 1'b0;
      end else if (cmd.put_minus) begin
         sign_ff <= 1'b0;
      end else if (cmd.put_digit) begin
         started_ff <= 1'b1;
         if (di_ff == '0) live_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff  <= req_character;
         color_ff <= req_color;
         addr_ff  <= req_cell_address;
         bin_ff   <= ((req_action == ACT_SDEC) && req_number[31]) ? (~req_number) + 32'd1
                                                                  : req_number;
         bcd_ff   <= '0;
         bits_ff  <= BW'(NUM_BITS);
         di_ff    <= DW'(DIGITS - 1);
      end else if (cmd.conv_step) begin
         bcd_ff  <= {adj[4*DIGITS-2:0], bin_ff[31]};
         bin_ff  <= {bin_ff[30:0], 1'b0};
         bits_ff <= bits_ff - 1'b1;
      end else if ((cmd.put_digit || cmd.skip_digit) && di_ff != '0) begin
         di_ff <= di_ff - 1'b1;
      end
   end

   // read result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rdc_ff <= '0;
         rda_ff <= '0;
      end else if (cmd.read_capture && addr_ok) begin
         rdc_ff <= rd_q_ff[7:0];
         rda_ff <= rd_q_ff[15:8];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         o_row_ff <= 5'(row_ff);
         o_col_ff <= 7'(col_ff);
         o_pos_ff <= 11'(row_ff * SCREEN_COLUMNS + col_ff);
         o_ch_ff  <= rdc_ff;
         o_co_ff  <= rda_ff;
      end
   end

   // status
   assign status.sweep_last   = (cnt_ff == NW'(CELLS - 1));
   assign status.scroll_end   = (cnt_ff == NW'(CELLS));
   assign status.scroll_need  = (row_ff == RW'(SCREEN_ROWS));
   assign status.conv_done    = (bits_ff == '0);
   assign status.sign_pending = sign_ff;
   assign status.dig_live     = live_ff;
   assign status.digit_skip   = (digit == 4'd0) && !started_ff && (di_ff != '0);
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_row      = o_row_ff;
   assign rsp_cursor_column   = o_col_ff;
   assign rsp_cursor_position = o_pos_ff;
   assign rsp_read_character  = o_ch_ff;
   assign rsp_read_color      = o_co_ff;

   `TCW_CHECK(a_row_range, 32'(row_ff) <= SCREEN_ROWS, "cursor row beyond scroll point")
   `TCW_CHECK(a_col_range, 32'(col_ff) < SCREEN_COLUMNS, "cursor column beyond line end")
   `TCW_CHECK_NEXT(a_load_valid, cmd.rsp_load, rsp_valid_ff, "loaded result not offered")

endmodule

>>> src/text_console_writer.sv
`timescale 1ns / 1ps
// put and new line write or move then check for a scroll, read issues then captures;
// an unknown action goes straight to its result, clear sweeps every cell, and decimal
// shifts in each bit and then puts its digits, with a minus sign first if negative;
// each scroll sweeps the store; the next item can be accepted in the cycle the result is
// offered, one item at a time; reset is synchronous: a pass over every cell then fills
// the store with blanks (space, attribute 0x0f); no item is accepted during that pass
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_character,
   input  logic [7:0]  req_color,
   input  logic [31:0] req_number,
   input  logic [10:0] req_cell_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_read_character,
   output logic [7:0]  rsp_read_color,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // screen store, cursor and number conversion
   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_character       (req_character),
      .req_color           (req_color),
      .req_number          (req_number),
      .req_cell_address    (req_cell_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_character  (rsp_read_character),
      .rsp_read_color      (rsp_read_color)
   );

endmodule

>>> test/text_console_writer_tb.sv
`timescale 1ns / 1ps
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLS * ROWS;
   localparam int STALL_LIMIT = 60000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [2:0] ACT_NOP_A = 3'd6;
   localparam logic [2:0] ACT_NOP_B = 3'd7;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  character;
      logic [7:0]  color;
      logic [31:0] number;
      logic [10:0] cell_address;
   } console_cmd_type;

   typedef struct {
      logic [4:0]  row;
      logic [6:0]  column;
      logic [10:0] position;
      logic [7:0]  rd_char;
      logic [7:0]  rd_color;
   } cursor_report_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_action;
   logic [7:0]  req_character;
   logic [7:0]  req_color;
   logic [31:0] req_number;
   logic [10:0] req_cell_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_column;
   logic [10:0] rsp_cursor_position;
   logic [7:0]  rsp_read_character;
   logic [7:0]  rsp_read_color;
   logic        csr_write_enable;
   logic [7:0]  csr_write_data;

   // console state as predicted
   logic [15:0] screen_copy [0:CELLS-1];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [7:0]  blank_attr;

   console_cmd_type   cmds_pending[$];
   cursor_report_type reports_due[$];
   int  error_count;
   int  send_gap;
   int  recv_gap;
   int  hold_left;
   int  reports_seen;
   int  quiet_cycles;
   bit  steady_flow;
   bit  hold_done;

   text_console_writer #(.SCREEN_COLUMNS(COLS), .SCREEN_ROWS(ROWS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_character(req_character), .req_color(req_color),
      .req_number(req_number), .req_cell_address(req_cell_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cursor_row(rsp_cursor_row), .rsp_cursor_column(rsp_cursor_column),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_read_character(rsp_read_character), .rsp_read_color(rsp_read_color),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // scroll up one line once the cursor falls off the bottom
   task automatic scroll_screen();
      if (cur_row >= ROWS) begin
         for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_copy[i] = screen_copy[i + COLS];
         for (int i = 0; i < COLS; i++) screen_copy[(ROWS - 1) * COLS + i] = {blank_attr, SPACE_CODE};
         cur_row = ROWS - 1;
      end
   endtask

   task automatic write_cell(logic [7:0] ch, logic [7:0] attr);
      int unsigned idx;
      idx = cur_row * COLS + cur_col;
      if (idx < CELLS) screen_copy[idx] = {attr, ch};
      cur_col++;
      if (cur_col >= COLS) begin
         cur_col = 0;
         cur_row++;
      end
      scroll_screen();
   endtask

   task automatic print_decimal(logic [31:0] value, logic [7:0] attr);
      logic [31:0] divisor;
      logic [31:0] digit;
      bit started;
      divisor = 32'd1000000000;
      started = 0;
      while (divisor != 0) begin
         digit = value / divisor;
         value = value - digit * divisor;
         divisor = divisor / 10;
         if (digit != 0 || started || divisor == 0) begin
            write_cell(8'h30 + digit[7:0], attr);
            started = 1;
         end
      end
   endtask

   // apply one accepted command and queue the cursor report it must give
   task automatic apply_console_action(console_cmd_type c);
      cursor_report_type r;
      logic [31:0] mag;
      r.rd_char = '0;
      r.rd_color = '0;
      case (c.action)
         ACT_PUT: write_cell(c.character, c.color);
         ACT_NEWLINE: begin
            cur_row++;
            cur_col = 0;
            scroll_screen();
         end
         ACT_UDEC: print_decimal(c.number, c.color);
         ACT_SDEC: begin
            mag = c.number;
            if (mag[31]) begin
               write_cell(MINUS_CODE, c.color);
               mag = ~mag + 1;
            end
            print_decimal(mag, c.color);
         end
         ACT_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_copy[i] = {blank_attr, SPACE_CODE};
            cur_row = 0;
            cur_col = 0;
         end
         ACT_READ: if (c.cell_address < CELLS) begin
            r.rd_char = screen_copy[c.cell_address][7:0];
            r.rd_color = screen_copy[c.cell_address][15:8];
         end
         default: ;
      endcase
      r.row = cur_row[4:0];
      r.column = cur_col[6:0];
      r.position = 11'(cur_row * COLS + cur_col);
      reports_due.push_back(r);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // sender: one command per transfer, fed from the pending list
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            apply_console_action('{req_action, req_character, req_color, req_number,
                                   req_cell_address});
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (cmds_pending.size() > 0) begin
               console_cmd_type c;
               c = cmds_pending.pop_front();
               req_action <= c.action;
               req_character <= c.character;
               req_color <= c.color;
               req_number <= c.number;
               req_cell_address <= c.cell_address;
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // receiver: compare each report transfer and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected report, expected none actual row %0d col %0d",
                        $time, rsp_cursor_row, rsp_cursor_column);
               error_count++;
            end else begin
               cursor_report_type e;
               e = reports_due.pop_front();
               check_field("cursor_row", e.row, rsp_cursor_row);
               check_field("cursor_column", e.column, rsp_cursor_column);
               check_field("cursor_position", e.position, rsp_cursor_position);
               check_field("read_character", e.rd_char, rsp_read_character);
               check_field("read_color", e.rd_color, rsp_read_color);
            end
            reports_seen++;
         end
         // long hold-off once, so the block backs up into its input
         if (reports_seen == 30 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            recv_gap <= 0;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("text_console_writer verification failed");
         $finish;
      end
   end

   function automatic console_cmd_type random_cmd();
      console_cmd_type c;
      int roll;
      roll = $urandom_range(0, 99);
      c.character = 8'($urandom);
      c.color = 8'($urandom);
      c.number = $urandom;
      if ($urandom_range(0, 3) == 0) c.number = $urandom_range(0, 999);
      c.cell_address = 11'($urandom);
      if (roll < 35) c.action = ACT_PUT;
      else if (roll < 52) c.action = ACT_NEWLINE;
      else if (roll < 66) c.action = ACT_UDEC;
      else if (roll < 80) c.action = ACT_SDEC;
      else if (roll < 94) c.action = ACT_READ;
      else if (roll < 97) c.action = ACT_CLEAR;
      else c.action = roll[0] ? ACT_NOP_A : ACT_NOP_B;
      return c;
   endfunction

   task automatic wait_idle();
      while (cmds_pending.size() > 0 || req_valid || reports_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_blank_color(logic [7:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      blank_attr = v;
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_cmd(logic [2:0] a, logic [7:0] ch, logic [7:0] col,
                            logic [31:0] num, logic [10:0] addr);
      cmds_pending.push_back('{a, ch, col, num, addr});
   endtask

   initial begin
      logic [7:0] phase_colors [3];
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = '0;
      req_character = '0;
      req_color = '0;
      req_number = '0;
      req_cell_address = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      error_count = 0;
      reports_seen = 0;
      quiet_cycles = 0;
      steady_flow = 0;
      hold_done = 0;
      for (int i = 0; i < CELLS; i++) screen_copy[i] = {RESET_COLOR, SPACE_CODE};
      cur_row = 0;
      cur_col = 0;
      blank_attr = BLANK_COLOR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every action, signed corner cases, bad reads
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd0);
      queue_cmd(ACT_PUT, 8'h00, 8'h00, 32'h0, 11'd0);
      queue_cmd(ACT_PUT, 8'hFF, 8'hFF, 32'hFFFFFFFF, 11'h7FF);
      queue_cmd(ACT_UDEC, 8'h00, 8'h5A, 32'h0, 11'd0);
      queue_cmd(ACT_UDEC, 8'h00, 8'hA5, 32'hFFFFFFFF, 11'd0);
      queue_cmd(ACT_UDEC, 8'h00, 8'h11, 32'd1000000000, 11'd0);
      queue_cmd(ACT_SDEC, 8'h00, 8'h22, 32'h80000000, 11'd0);
      queue_cmd(ACT_SDEC, 8'h00, 8'h33, 32'hFFFFFFFF, 11'd0);
      queue_cmd(ACT_SDEC, 8'h00, 8'h44, 32'h7FFFFFFF, 11'd0);
      queue_cmd(ACT_SDEC, 8'h00, 8'h55, 32'h0, 11'd0);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd1);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd12);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd1999);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd2000);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'h7FF);
      queue_cmd(ACT_NOP_A, 8'h41, 8'h07, 32'h0, 11'd0);
      queue_cmd(ACT_NOP_B, 8'h41, 8'h07, 32'h0, 11'd0);
      // long numbers wrap past the line end
      for (int i = 0; i < 5; i++) queue_cmd(ACT_SDEC, 8'h00, 8'h1E, 32'h80000000, 11'd0);
      queue_cmd(ACT_NEWLINE, 8'h00, 8'h00, 32'h0, 11'd0);
      queue_cmd(ACT_CLEAR, 8'h00, 8'h00, 32'h0, 11'd0);
      queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd0);

      // random phases across blank colors, newlines push through scrolls
      phase_colors[0] = 8'h00;
      phase_colors[1] = 8'hFF;
      phase_colors[2] = 8'($urandom);
      for (int p = 0; p < 3; p++) begin
         set_blank_color(phase_colors[p]);
         steady_flow = (p == 1);
         if (p == 0) queue_cmd(ACT_CLEAR, 8'h00, 8'h00, 32'h0, 11'd0);
         // a marked full screen of lines forces at least one scroll
         for (int i = 0; i < ROWS; i++) begin
            queue_cmd(ACT_PUT, 8'(8'h41 + i), 8'(p + 1), 32'h0, 11'd0);
            queue_cmd(ACT_NEWLINE, 8'h00, 8'h00, 32'h0, 11'd0);
         end
         queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'd0);
         queue_cmd(ACT_READ, 8'h00, 8'h00, 32'h0, 11'((ROWS - 1) * COLS));
         for (int i = 0; i < 33; i++) cmds_pending.push_back(random_cmd());
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("text_console_writer verification clean");
      else $display("text_console_writer verification failed");
      $finish;
   end

endmodule
